>>> hw/rtl/gapf_pkg.sv
`timescale 1ns / 1ps

package gapf_pkg;

    // Map geometry: 32 x 32 cells, cell index is {row, column}
    localparam int COORD_W    = 5;
    localparam int CELL_W     = 2 * COORD_W;
    localparam int CELLS      = 1 << CELL_W;

    // Open list
    localparam int OPEN_DEPTH = 2048;
    localparam int HEAP_AW    = $clog2(OPEN_DEPTH);
    localparam int CNT_W      = HEAP_AW + 1;

    // Entry field widths
    localparam int G_W        = CELL_W + 1;
    localparam int H_W        = COORD_W + 1;
    localparam int F_W        = G_W + 1;
    localparam int SEQ_W      = 14;
    localparam int DIR_W      = 3;
    localparam int COST_W     = 10;

    // Opcodes of the input channel
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic               wall;
        logic [COORD_W-1:0] goal_x;
        logic [COORD_W-1:0] goal_y;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic               overflow;
        logic [COORD_W-1:0] next_x;
        logic [COORD_W-1:0] next_y;
        logic [COST_W-1:0]  path_cost;
    } out_item_t;

    typedef struct packed {
        logic [G_W-1:0]     g;
        logic [H_W-1:0]     h;
        logic [SEQ_W-1:0]   seq;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIR_W-1:0]   dir;
    } entry_t;

    typedef struct packed {
        logic   clear;
        logic   push;
        logic   pop;
        entry_t ent;
    } hp_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } hp_stat_t;

    // Order: smaller g+h, then smaller h, then earlier push
    function automatic logic entry_before(input entry_t a, input entry_t b);
        logic [F_W-1:0] fa;
        logic [F_W-1:0] fb;
        logic           res;
        fa = F_W'(a.g) + F_W'(a.h);
        fb = F_W'(b.g) + F_W'(b.h);
        if (fa != fb) begin
            res = (fa < fb);
        end else if (a.h != b.h) begin
            res = (a.h < b.h);
        end else begin
            res = (a.seq < b.seq);
        end
        return res;
    endfunction

    // Column step of a direction, as a 6-bit two's complement value
    function automatic logic [COORD_W:0] step_dx(input logic [DIR_W-1:0] d);
        logic [COORD_W:0] v;
        unique case (d)
            3'd0, 3'd3, 3'd5: v = '1;
            3'd1, 3'd6:       v = '0;
            default:          v = (COORD_W+1)'(1);
        endcase
        return v;
    endfunction

    // Row step of a direction, as a 6-bit two's complement value
    function automatic logic [COORD_W:0] step_dy(input logic [DIR_W-1:0] d);
        logic [COORD_W:0] v;
        unique case (d)
            3'd0, 3'd1, 3'd2: v = '1;
            3'd3, 3'd4:       v = '0;
            default:          v = (COORD_W+1)'(1);
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/gapf_heap.sv
`timescale 1ns / 1ps

module gapf_heap (
    input  logic              aclk,
    input  logic              aresetn,
    input  gapf_pkg::hp_cmd_t cmd,
    output gapf_pkg::hp_stat_t stat,
    output gapf_pkg::entry_t  top
);

    localparam logic [2:0] HS_IDLE    = 3'd0;
    localparam logic [2:0] HS_PU_CMP  = 3'd1;
    localparam logic [2:0] HS_PU_FIN  = 3'd2;
    localparam logic [2:0] HS_PO_TOP  = 3'd3;
    localparam logic [2:0] HS_PO_LAST = 3'd4;
    localparam logic [2:0] HS_SD_L    = 3'd5;
    localparam logic [2:0] HS_SD_R    = 3'd6;
    localparam logic [2:0] HS_SD_CMP  = 3'd7;

    gapf_pkg::entry_t heap_mem [gapf_pkg::OPEN_DEPTH];

    logic [2:0]                      state_reg, state_next;
    logic [gapf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [gapf_pkg::HEAP_AW-1:0]    idx_reg, idx_next;
    gapf_pkg::entry_t                ent_reg, ent_next;
    gapf_pkg::entry_t                top_reg, top_next;
    gapf_pkg::entry_t                left_reg, left_next;
    logic                            rv_reg, rv_next;
    gapf_pkg::entry_t                rd_reg;

    logic                            we;
    logic [gapf_pkg::HEAP_AW-1:0]    waddr;
    logic [gapf_pkg::HEAP_AW-1:0]    raddr;
    gapf_pkg::entry_t                wdata;

    logic [gapf_pkg::HEAP_AW-1:0]    par_idx;
    logic [gapf_pkg::HEAP_AW-1:0]    par_cnt;
    logic [gapf_pkg::HEAP_AW-1:0]    par_par;
    logic [gapf_pkg::CNT_W:0]        lc;
    logic [gapf_pkg::CNT_W:0]        rc;
    gapf_pkg::entry_t                best;
    logic [gapf_pkg::HEAP_AW-1:0]    best_idx;

    assign par_idx = (idx_reg - 1'b1) >> 1;
    assign par_cnt = (cnt_reg[gapf_pkg::HEAP_AW-1:0] - 1'b1) >> 1;
    assign par_par = (par_idx - 1'b1) >> 1;
    assign lc      = {1'b0, idx_reg, 1'b1};
    assign rc      = lc + 1'b1;

    // Pick the better child
    always_comb begin
        best     = left_reg;
        best_idx = lc[gapf_pkg::HEAP_AW-1:0];
        if (rv_reg && gapf_pkg::entry_before(rd_reg, left_reg)) begin
            best     = rd_reg;
            best_idx = rc[gapf_pkg::HEAP_AW-1:0];
        end
    end

    // Heap memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        rd_reg <= heap_mem[raddr];
    end

    // Sift sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ent_next   = ent_reg;
        top_next   = top_reg;
        left_next  = left_reg;
        rv_next    = rv_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wdata      = ent_reg;
        raddr      = '0;
        unique case (state_reg)
            HS_IDLE: begin
                if (cmd.clear) begin
                    cnt_next = '0;
                end else if (cmd.push) begin
                    ent_next = cmd.ent;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0) begin
                        we    = 1'b1;
                        waddr = '0;
                        wdata = cmd.ent;
                    end else begin
                        idx_next   = cnt_reg[gapf_pkg::HEAP_AW-1:0];
                        raddr      = par_cnt;
                        state_next = HS_PU_CMP;
                    end
                end else if (cmd.pop) begin
                    cnt_next   = cnt_reg - 1'b1;
                    raddr      = '0;
                    state_next = HS_PO_TOP;
                end
            end
            HS_PU_CMP: begin
                if (gapf_pkg::entry_before(ent_reg, rd_reg)) begin
                    we       = 1'b1;
                    wdata    = rd_reg;
                    idx_next = par_idx;
                    if (par_idx == '0) begin
                        state_next = HS_PU_FIN;
                    end else begin
                        raddr = par_par;
                    end
                end else begin
                    we         = 1'b1;
                    state_next = HS_IDLE;
                end
            end
            HS_PU_FIN: begin
                we         = 1'b1;
                state_next = HS_IDLE;
            end
            HS_PO_TOP: begin
                top_next = rd_reg;
                if (cnt_reg == '0) begin
                    state_next = HS_IDLE;
                end else begin
                    raddr      = cnt_reg[gapf_pkg::HEAP_AW-1:0];
                    state_next = HS_PO_LAST;
                end
            end
            HS_PO_LAST: begin
                ent_next   = rd_reg;
                idx_next   = '0;
                state_next = HS_SD_L;
            end
            HS_SD_L: begin
                if (lc >= {1'b0, cnt_reg}) begin
                    we         = 1'b1;
                    state_next = HS_IDLE;
                end else begin
                    raddr      = lc[gapf_pkg::HEAP_AW-1:0];
                    state_next = HS_SD_R;
                end
            end
            HS_SD_R: begin
                left_next = rd_reg;
                rv_next   = (rc < {1'b0, cnt_reg});
                raddr     = rc[gapf_pkg::HEAP_AW-1:0];
                state_next = HS_SD_CMP;
            end
            HS_SD_CMP: begin
                we = 1'b1;
                if (gapf_pkg::entry_before(best, ent_reg)) begin
                    wdata      = best;
                    idx_next   = best_idx;
                    state_next = HS_SD_L;
                end else begin
                    state_next = HS_IDLE;
                end
            end
            default: state_next = HS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        idx_reg  <= idx_next;
        ent_reg  <= ent_next;
        top_reg  <= top_next;
        left_reg <= left_next;
        rv_reg   <= rv_next;
    end

    assign stat.busy  = (state_reg != HS_IDLE);
    assign stat.count = cnt_reg;
    assign top        = top_reg;

endmodule

>>> hw/rtl/grid_astar_path_finder.sv
`timescale 1ns / 1ps

// Grid path finder over a 32 x 32 wall map with an 8-connected A* search.
// After reset the wall map is cleared in a pass over every cell with s_ready
// low. A write item writes one wall bit of the map. A query first clears the
// closed map, then runs the search: each pop sifts down the open-list heap
// memory level by level, each push sifts up level by level, and each of the
// eight neighbour tests reads the map memory before the push. A found path
// is traced back step by step along the stored parent directions. The single
// read port of the heap memory and the registered map memory read set the
// query time. One item is worked at a time; a result waits in the output
// register.
module grid_astar_path_finder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  gapf_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output gapf_pkg::out_item_t  m_data
);

    localparam logic [3:0] ST_INIT = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_CLR  = 4'd2;
    localparam logic [3:0] ST_SPW  = 4'd3;
    localparam logic [3:0] ST_POP  = 4'd4;
    localparam logic [3:0] ST_POPW = 4'd5;
    localparam logic [3:0] ST_EVAL = 4'd6;
    localparam logic [3:0] ST_CHK  = 4'd7;
    localparam logic [3:0] ST_NRD  = 4'd8;
    localparam logic [3:0] ST_NCHK = 4'd9;
    localparam logic [3:0] ST_PUW  = 4'd10;
    localparam logic [3:0] ST_TR   = 4'd11;
    localparam logic [3:0] ST_TRD  = 4'd12;
    localparam logic [3:0] ST_RES  = 4'd13;

    localparam int CW = gapf_pkg::COORD_W;
    localparam int AW = gapf_pkg::CELL_W;

    // Map memories: wall bits, and {closed, parent direction}
    logic                        wall_mem [gapf_pkg::CELLS];
    logic [gapf_pkg::DIR_W:0]    cl_mem   [gapf_pkg::CELLS];

    logic                        wall_we;
    logic [AW-1:0]               wall_waddr;
    logic                        wall_wdata;
    logic                        cl_we;
    logic [AW-1:0]               cl_waddr;
    logic [gapf_pkg::DIR_W:0]    cl_wdata;
    logic [AW-1:0]               map_raddr;
    logic                        wall_q;
    logic [gapf_pkg::DIR_W:0]    cl_q;

    logic [3:0]                  state_reg, state_next;
    logic [AW:0]                 sweep_reg, sweep_next;
    logic [CW-1:0]               sx_reg, sx_next;
    logic [CW-1:0]               sy_reg, sy_next;
    logic [CW-1:0]               gx_reg, gx_next;
    logic [CW-1:0]               gy_reg, gy_next;
    gapf_pkg::entry_t            cur_reg, cur_next;
    logic [gapf_pkg::DIR_W-1:0]  k_reg, k_next;
    logic [gapf_pkg::SEQ_W-1:0]  seq_reg, seq_next;
    logic [CW-1:0]               cx_reg, cx_next;
    logic [CW-1:0]               cy_reg, cy_next;
    logic [gapf_pkg::G_W-1:0]    s_reg, s_next;
    gapf_pkg::out_item_t         res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    gapf_pkg::out_item_t         m_data_reg, m_data_next;

    gapf_pkg::hp_cmd_t           hp_cmd;
    gapf_pkg::hp_stat_t          hp_stat;
    gapf_pkg::entry_t            hp_top;

    logic [CW:0]                 nx6;
    logic [CW:0]                 ny6;
    logic                        n_ok;
    logic [CW-1:0]               hdx;
    logic [CW-1:0]               hdy;
    logic [CW:0]                 tdx;
    logic [CW:0]                 tdy;
    logic [gapf_pkg::COST_W-1:0] cost_sat;
    logic                        sweep_last;

    gapf_heap u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hp_cmd),
        .stat    (hp_stat),
        .top     (hp_top)
    );

    // Map memories with registered read
    always_ff @(posedge aclk) begin
        if (wall_we) begin
            wall_mem[wall_waddr] <= wall_wdata;
        end
        if (cl_we) begin
            cl_mem[cl_waddr] <= cl_wdata;
        end
        wall_q <= wall_mem[map_raddr];
        cl_q   <= cl_mem[map_raddr];
    end

    // Neighbour of the current cell and its heuristic
    assign nx6  = {1'b0, cur_reg.x} + gapf_pkg::step_dx(k_reg);
    assign ny6  = {1'b0, cur_reg.y} + gapf_pkg::step_dy(k_reg);
    assign n_ok = !nx6[CW] && (nx6[CW-1:0] != '0) && !ny6[CW] && (ny6[CW-1:0] != '0);
    assign hdx  = (nx6[CW-1:0] > gx_reg) ? (nx6[CW-1:0] - gx_reg) : (gx_reg - nx6[CW-1:0]);
    assign hdy  = (ny6[CW-1:0] > gy_reg) ? (ny6[CW-1:0] - gy_reg) : (gy_reg - ny6[CW-1:0]);

    // Step back along the parent direction
    assign tdx  = gapf_pkg::step_dx(cl_q[gapf_pkg::DIR_W-1:0]);
    assign tdy  = gapf_pkg::step_dy(cl_q[gapf_pkg::DIR_W-1:0]);

    assign cost_sat   = (cur_reg.g > gapf_pkg::G_W'(1023)) ? '1
                                                           : cur_reg.g[gapf_pkg::COST_W-1:0];
    assign sweep_last = (sweep_reg[AW-1:0] == '1);

    // Search sequencer
    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        cur_next     = cur_reg;
        k_next       = k_reg;
        seq_next     = seq_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        s_next       = s_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        wall_we      = 1'b0;
        wall_waddr   = sweep_reg[AW-1:0];
        wall_wdata   = 1'b0;
        cl_we        = 1'b0;
        cl_waddr     = {cur_reg.y, cur_reg.x};
        cl_wdata     = {1'b1, cur_reg.dir};
        map_raddr    = {cur_reg.y, cur_reg.x};
        hp_cmd       = '0;
        hp_cmd.ent.g   = cur_reg.g + 1'b1;
        hp_cmd.ent.h   = gapf_pkg::H_W'(hdx) + gapf_pkg::H_W'(hdy);
        hp_cmd.ent.seq = seq_reg;
        hp_cmd.ent.x   = nx6[CW-1:0];
        hp_cmd.ent.y   = ny6[CW-1:0];
        hp_cmd.ent.dir = k_reg;
        unique case (state_reg)
            ST_INIT: begin
                wall_we    = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.opcode == gapf_pkg::OP_WRITE) begin
                        wall_we    = 1'b1;
                        wall_waddr = {s_data.cell_y, s_data.cell_x};
                        wall_wdata = s_data.wall;
                    end else begin
                        sx_next      = s_data.cell_x;
                        sy_next      = s_data.cell_y;
                        gx_next      = s_data.goal_x;
                        gy_next      = s_data.goal_y;
                        sweep_next   = '0;
                        hp_cmd.clear = 1'b1;
                        state_next   = ST_CLR;
                    end
                end
            end
            ST_CLR: begin
                cl_we      = 1'b1;
                cl_waddr   = sweep_reg[AW-1:0];
                cl_wdata   = '0;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    hp_cmd.push = 1'b1;
                    hp_cmd.ent  = '0;
                    hp_cmd.ent.x = sx_reg;
                    hp_cmd.ent.y = sy_reg;
                    seq_next    = gapf_pkg::SEQ_W'(1);
                    state_next  = ST_SPW;
                end
            end
            ST_SPW: begin
                if (!hp_stat.busy) begin
                    state_next = ST_POP;
                end
            end
            ST_POP: begin
                if (hp_stat.count == '0) begin
                    res_next   = '0;
                    state_next = ST_RES;
                end else begin
                    hp_cmd.pop = 1'b1;
                    state_next = ST_POPW;
                end
            end
            ST_POPW: begin
                if (!hp_stat.busy) begin
                    cur_next   = hp_top;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (cur_reg.x == gx_reg && cur_reg.y == gy_reg) begin
                    if (cur_reg.g == '0) begin
                        res_next           = '0;
                        res_next.found     = 1'b1;
                        res_next.next_x    = cur_reg.x;
                        res_next.next_y    = cur_reg.y;
                        state_next         = ST_RES;
                    end else begin
                        cl_we      = 1'b1;
                        cx_next    = cur_reg.x;
                        cy_next    = cur_reg.y;
                        s_next     = cur_reg.g;
                        state_next = ST_TR;
                    end
                end else begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (cl_q[gapf_pkg::DIR_W]) begin
                    state_next = ST_POP;
                end else begin
                    cl_we      = 1'b1;
                    k_next     = '0;
                    state_next = ST_NRD;
                end
            end
            ST_NRD: begin
                map_raddr = {ny6[CW-1:0], nx6[CW-1:0]};
                if (n_ok) begin
                    state_next = ST_NCHK;
                end else if (k_reg == '1) begin
                    state_next = ST_POP;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_NCHK: begin
                if (wall_q || cl_q[gapf_pkg::DIR_W]) begin
                    if (k_reg == '1) begin
                        state_next = ST_POP;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_NRD;
                    end
                end else if (hp_stat.count >= gapf_pkg::CNT_W'(gapf_pkg::OPEN_DEPTH)) begin
                    res_next          = '0;
                    res_next.overflow = 1'b1;
                    state_next        = ST_RES;
                end else begin
                    hp_cmd.push = 1'b1;
                    seq_next    = seq_reg + 1'b1;
                    state_next  = ST_PUW;
                end
            end
            ST_PUW: begin
                if (!hp_stat.busy) begin
                    if (k_reg == '1) begin
                        state_next = ST_POP;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_NRD;
                    end
                end
            end
            ST_TR: begin
                map_raddr = {cy_reg, cx_reg};
                if (s_reg <= gapf_pkg::G_W'(1)) begin
                    res_next           = '0;
                    res_next.found     = 1'b1;
                    res_next.next_x    = cx_reg;
                    res_next.next_y    = cy_reg;
                    res_next.path_cost = cost_sat;
                    state_next         = ST_RES;
                end else begin
                    state_next = ST_TRD;
                end
            end
            ST_TRD: begin
                cx_next    = cx_reg - tdx[CW-1:0];
                cy_next    = cy_reg - tdy[CW-1:0];
                s_next     = s_reg - 1'b1;
                state_next = ST_TR;
            end
            ST_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        seq_reg    <= seq_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        s_reg      <= s_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    // Open list never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        hp_stat.count <= gapf_pkg::CNT_W'(gapf_pkg::OPEN_DEPTH))
        else $error("open list count above depth");

    // A push is never issued into a full open list
    assert property (@(posedge aclk) disable iff (!aresetn)
        hp_cmd.push |-> hp_stat.count < gapf_pkg::CNT_W'(gapf_pkg::OPEN_DEPTH))
        else $error("push into full open list");

    // Heap is quiet whenever a new item may be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hp_stat.busy)
        else $error("input ready while heap busy");
`endif

endmodule
